// ===== hdl/vrta_pkg.sv =====
// Shared types and constants of the vertical resize tap accumulator.
`timescale 1ns / 1ps
package vrta_pkg;

    localparam int COL_W          = 12;
    localparam int TAPCNT_W       = 3;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 18;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int LANES          = 4;
    localparam int GROUP_W        = PROD_W + $clog2(LANES);
    localparam int ACC_W          = 48;

    // Taps taken per group: the smaller of the lane count and the group size.
    localparam int GROUP_TAPS     = 4;
    localparam int TAP_LIMIT      = (GROUP_TAPS < LANES) ? GROUP_TAPS : LANES;

    localparam int LINE_WIDTH_DEF = 4096;

    // Reciprocal used to reduce the column modulo the line width.
    localparam int RECIP_SH       = 24;
    localparam int RECIP_W        = 23;
    localparam int Q_W            = COL_W + RECIP_W - RECIP_SH;
    localparam int MOD_W          = 17;

    localparam int IN_DATA_W      = 152;
    localparam int OUT_DATA_W     = 64;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [GROUP_W-1:0]  t_group;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== hdl/vrta_tap_mac.sv =====
// Four-lane tap multiplier with registered products and a registered group sum.
`timescale 1ns / 1ps
module vrta_tap_mac (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_advance,
    input  logic [vrta_pkg::TAPCNT_W-1:0]     i_tap_count,
    input  vrta_pkg::t_sample                 i_sample [vrta_pkg::LANES],
    input  vrta_pkg::t_coef                   i_coef   [vrta_pkg::LANES],
    output vrta_pkg::t_group                  o_group
);
    import vrta_pkg::*;

    t_prod  r_prod [LANES];
    t_group r_group;
    t_group n_group;

    // Zero the lanes beyond the valid tap count.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            if (i_load) begin
                if ((i < TAP_LIMIT) && (int'(i_tap_count) > i)) begin
                    r_prod[i] <= t_prod'(i_sample[i]) * t_prod'(i_coef[i]);
                end else begin
                    r_prod[i] <= '0;
                end
            end
        end
    end

    always_comb begin
        n_group = '0;
        for (int i = 0; i < LANES; i++) begin
            n_group = n_group + t_group'(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_group <= n_group;
        end
    end

    assign o_group = r_group;

endmodule

// ===== hdl/vrta_sum_ram.sv =====
// Column sum memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module vrta_sum_ram #(
    parameter int DEPTH = vrta_pkg::LINE_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  vrta_pkg::t_acc  i_wr_data,
    output vrta_pkg::t_acc  o_rd_data
);
    import vrta_pkg::*;

    t_acc r_mem [DEPTH];
    t_acc r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/vertical_resize_tap_accumulator.sv =====
// Top level: request pipeline, column sum read-modify-write with forwarding.
// From the accepting edge to o_m_tvalid a request passes the registered multiply,
// memory read, base select, then accumulate and saturate into the output register.
// Throughput: one request per cycle unless the output stalls, bounded by the
// single read and single write port of the column sum memory; back-to-back
// updates of one column are resolved by forwarding. Reset clears all valid flags;
// column sums are undefined until a first-group request writes them. No clearing pass.
`timescale 1ns / 1ps
module vertical_resize_tap_accumulator #(
    parameter int LINE_WIDTH = vrta_pkg::LINE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // column[11:0], tap_count[14:12], sample_a..d[78:15], coef_a..d[150:79], pad
    input  logic [vrta_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // first_group[0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_column[11:0], column_value[59:12], pad
    output logic [vrta_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import vrta_pkg::*;

    localparam int AW    = $clog2(LINE_WIDTH);
    localparam int RECIP = (1 << RECIP_SH) / LINE_WIDTH;

    // Unpack the request.
    logic [COL_W-1:0]    w_col;
    logic [TAPCNT_W-1:0] w_tap_count;
    t_sample             w_sample [LANES];
    t_coef               w_coef   [LANES];

    assign w_col       = i_s_tdata[COL_W-1:0];
    assign w_tap_count = i_s_tdata[COL_W +: TAPCNT_W];

    for (genvar g = 0; g < LANES; g++) begin : g_unpack
        assign w_sample[g] = i_s_tdata[COL_W + TAPCNT_W + g*SAMPLE_W +: SAMPLE_W];
        assign w_coef[g]   = i_s_tdata[COL_W + TAPCNT_W + LANES*SAMPLE_W + g*COEF_W +: COEF_W];
    end

    // Stage control.
    logic r_v1, r_v2, r_v3, r_ov;
    logic w_adv_o, w_adv3, w_adv2, w_adv1;
    logic w_accept, w_mv12, w_mv23, w_wr_en;

    assign w_adv_o   = !r_ov || i_m_tready;
    assign w_adv3    = !r_v3 || w_adv_o;
    assign w_adv2    = !r_v2 || w_adv3;
    assign w_adv1    = !r_v1 || w_adv2;
    assign o_s_tready = w_adv1;
    assign w_accept  = i_s_tvalid && w_adv1;
    assign w_mv12    = r_v1 && w_adv2;
    assign w_mv23    = r_v2 && w_adv3;
    assign w_wr_en   = r_v3 && w_adv_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_s_tvalid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv_o) r_ov <= r_v3;
        end
    end

    // Stage 1: quotient estimate of column / line width.
    logic [COL_W+RECIP_W-1:0] w_qmul;
    logic [COL_W-1:0]         r_col1;
    logic                     r_first1;
    logic [Q_W-1:0]           r_q1;

    assign w_qmul = (COL_W+RECIP_W)'(w_col) * (COL_W+RECIP_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col1   <= w_col;
            r_first1 <= i_s_tuser;
            r_q1     <= w_qmul[COL_W+RECIP_W-1:RECIP_SH];
        end
    end

    // Remainder with one correction step gives the memory index.
    logic [MOD_W+Q_W-1:0] w_ql;
    logic [MOD_W-1:0]     w_rem;
    logic [MOD_W-1:0]     w_rem_fix;
    logic [AW-1:0]        w_idx1;

    assign w_ql      = (MOD_W+Q_W)'(r_q1) * (MOD_W+Q_W)'(LINE_WIDTH);
    assign w_rem     = MOD_W'(r_col1) - w_ql[MOD_W-1:0];
    assign w_rem_fix = (w_rem >= MOD_W'(LINE_WIDTH)) ? (w_rem - MOD_W'(LINE_WIDTH)) : w_rem;
    assign w_idx1    = w_rem_fix[AW-1:0];

    t_group w_group;

    vrta_tap_mac u_mac (
        .i_clk       (i_clk),
        .i_load      (w_accept),
        .i_advance   (w_mv12),
        .i_tap_count (w_tap_count),
        .i_sample    (w_sample),
        .i_coef      (w_coef),
        .o_group     (w_group)
    );

    // Stage 2: memory read data plus any write that landed on the read edge.
    logic [COL_W-1:0] r_col2;
    logic             r_first2;
    logic [AW-1:0]    r_idx2;
    logic             r_f2_v;
    t_acc             r_f2_d;
    t_acc             w_rd_data;
    t_acc             w_acc;
    logic [COL_W-1:0] r_col3;
    logic             r_first3;
    logic [AW-1:0]    r_idx3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (w_mv12) begin
            r_f2_v <= w_wr_en && (r_idx3 == w_idx1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv12) begin
            r_col2   <= r_col1;
            r_first2 <= r_first1;
            r_idx2   <= w_idx1;
            r_f2_d   <= w_acc;
        end
    end

    vrta_sum_ram #(
        .DEPTH (LINE_WIDTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_mv12),
        .i_rd_addr (w_idx1),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx3),
        .i_wr_data (w_acc),
        .o_rd_data (w_rd_data)
    );

    // Stage 3: the newest pending write to this column wins.
    t_acc   n_base;
    t_acc   r_base3;
    t_group r_grp3;

    always_comb begin
        priority if (r_v3 && (r_idx3 == r_idx2)) begin
            n_base = w_acc;
        end else if (r_f2_v) begin
            n_base = r_f2_d;
        end else begin
            n_base = w_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv23) begin
            r_col3   <= r_col2;
            r_first3 <= r_first2;
            r_idx3   <= r_idx2;
            r_base3  <= n_base;
            r_grp3   <= w_group;
        end
    end

    // Accumulate and saturate.
    logic signed [ACC_W:0] w_sum;
    t_acc                  w_base_sel;

    assign w_base_sel = r_first3 ? '0 : r_base3;
    assign w_sum      = (ACC_W+1)'(w_base_sel) + (ACC_W+1)'(r_grp3);

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_acc = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc = w_sum[ACC_W-1:0];
        end
    end

    // Output register.
    logic [COL_W-1:0] r_ocol;
    t_acc             r_oval;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ocol <= r_col3;
            r_oval <= w_acc;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(OUT_DATA_W-COL_W-ACC_W)'(0), r_oval, r_ocol};

    // Checks.
    a_full_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_v3 && r_ov))
        else $error("input stalled while the pipeline has a free stage");

    a_write_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (o_m_tvalid && (r_oval == $past(w_acc))))
        else $error("column write not followed by its result");

    a_rise_from_s3 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_v3))
        else $error("result appeared without an item in the last stage");

    a_read_with_move : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mv23 |=> r_v3)
        else $error("item lost between read and accumulate stages");

endmodule
